FILE: hdl/tcw_pkg.sv
// Shared types and constants of the text console writer.
package tcw_pkg;

    // Fixed port widths
    localparam int CHAR_W  = 8;
    localparam int ATTR_W  = 8;
    localparam int INDEX_W = 11;
    localparam int OCOL_W  = 7;
    localparam int OROW_W  = 5;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'h0A;
    localparam logic [CHAR_W-1:0] BLANK_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h07;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_READ
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ADDR,
        S_ACCESS,
        S_SCROLL,
        S_DONE
    } t_state;

endpackage

FILE: hdl/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcw_front.sv
// Front end: classifies incoming words and queues them for the back end.
module tcw_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic                         i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]  i_cell_index,
    input  logic                         i_pop,
    output logic                         o_full,
    output logic                         o_cmd_valid,
    output tcw_pkg::t_cmd                o_cmd
);

    localparam int PW = $clog2(tcw_pkg::QUEUE_DEPTH);
    localparam int NW = $clog2(tcw_pkg::QUEUE_DEPTH + 1);

    tcw_pkg::t_cmd r_q [tcw_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_count, n_count;
    tcw_pkg::t_cmd cmd_in;

    // Classify: read, newline or character put
    always_comb begin
        cmd_in.char_code  = i_char_code;
        cmd_in.cell_index = i_cell_index;
        if (i_operation) begin
            cmd_in.kind = tcw_pkg::CMD_READ;
        end else if (i_char_code == tcw_pkg::NEWLINE_CODE) begin
            cmd_in.kind = tcw_pkg::CMD_NEWLINE;
        end else begin
            cmd_in.kind = tcw_pkg::CMD_PUT;
        end
    end

    always_comb begin
        n_wp    = i_push ? r_wp + 1'b1 : r_wp;
        n_rp    = i_pop  ? r_rp + 1'b1 : r_rp;
        n_count = r_count + NW'(i_push) - NW'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= cmd_in;
        end
    end

    assign o_full      = (r_count == NW'(tcw_pkg::QUEUE_DEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_q[r_rp];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < NW'(tcw_pkg::QUEUE_DEPTH)))
        else $error("push into full command queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("pop from empty command queue");

endmodule

FILE: hdl/tcw_back.sv
// Back end: executes queued commands against the screen store and cursor.
module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    input  logic                         i_cmd_valid,
    input  tcw_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    output logic                         o_clearing,
    output logic                         o_result_valid,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]   o_cell_attr,
    output logic [tcw_pkg::OCOL_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]   o_cursor_row,
    output logic                         o_scrolled
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int RW    = $clog2(ROWS);
    localparam int DW    = tcw_pkg::ATTR_W + tcw_pkg::CHAR_W;
    localparam logic [AW:0]   CELLS_X    = (AW+1)'(CELLS);
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELLS - 1);
    localparam logic [AW-1:0] LAST_COL_C = AW'(COLUMNS - 1);
    localparam logic [AW-1:0] LAST_BASE  = AW'(CELLS - COLUMNS);
    localparam logic [AW-1:0] COLS_A     = AW'(COLUMNS);

    tcw_pkg::t_state r_state, n_state;
    tcw_pkg::t_cmd   r_cmd, n_cmd;
    logic [CW-1:0]   r_col, n_col;
    logic [RW-1:0]   r_row, n_row;
    logic [AW-1:0]   r_top_base, n_top_base;   // physical start of screen row 0
    logic [AW-1:0]   r_lin, n_lin;
    logic [AW-1:0]   r_addr, n_addr;
    logic [AW-1:0]   r_cnt, n_cnt;
    logic            r_in_range, n_in_range;
    logic            r_scrolled, n_scrolled;
    logic [tcw_pkg::ATTR_W-1:0] r_attr;

    logic                         r_out_valid, n_out_valid;
    logic [tcw_pkg::CHAR_W-1:0]   r_out_char, n_out_char;
    logic [tcw_pkg::ATTR_W-1:0]   r_out_attr, n_out_attr;
    logic [CW-1:0]                r_out_col, n_out_col;
    logic [RW-1:0]                r_out_row, n_out_row;
    logic                         r_out_scrolled, n_out_scrolled;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [DW-1:0] ram_wdata, ram_rdata;

    logic          advance_row, row_last, need_scroll;
    logic [AW:0]   addr_sum;

    tcw_ram #(
        .WIDTH (DW),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        advance_row = (r_cmd.kind == tcw_pkg::CMD_NEWLINE) || (32'(r_col) == COLUMNS - 1);
        row_last    = (32'(r_row) == ROWS - 1);
        need_scroll = (r_cmd.kind != tcw_pkg::CMD_READ) && advance_row && row_last;
        addr_sum    = {1'b0, r_lin} + {1'b0, r_top_base};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tcw_pkg::S_CLEAR:  if (r_cnt == LAST_CELL) n_state = tcw_pkg::S_IDLE;
            tcw_pkg::S_IDLE:   if (i_cmd_valid) n_state = tcw_pkg::S_ADDR;
            tcw_pkg::S_ADDR:   n_state = tcw_pkg::S_ACCESS;
            tcw_pkg::S_ACCESS: n_state = need_scroll ? tcw_pkg::S_SCROLL : tcw_pkg::S_DONE;
            tcw_pkg::S_SCROLL: if (r_cnt == LAST_COL_C) n_state = tcw_pkg::S_DONE;
            tcw_pkg::S_DONE:   n_state = tcw_pkg::S_IDLE;
            default:           n_state = tcw_pkg::S_IDLE;
        endcase
    end

    // Control outputs
    always_comb begin
        o_pop     = 1'b0;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = r_addr;
        ram_raddr = r_addr;
        ram_wdata = {r_attr, r_cmd.char_code};
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
                ram_wdata = {tcw_pkg::RESET_ATTR, tcw_pkg::BLANK_CODE};
            end
            tcw_pkg::S_IDLE: begin
                o_pop = i_cmd_valid;
            end
            tcw_pkg::S_ACCESS: begin
                ram_we = (r_cmd.kind == tcw_pkg::CMD_PUT);
                ram_re = (r_cmd.kind == tcw_pkg::CMD_READ);
            end
            tcw_pkg::S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = r_top_base + r_cnt;
                ram_wdata = {r_attr, tcw_pkg::BLANK_CODE};
            end
            default: begin
            end
        endcase
    end

    // Datapath
    always_comb begin
        n_cmd          = r_cmd;
        n_col          = r_col;
        n_row          = r_row;
        n_top_base     = r_top_base;
        n_lin          = r_lin;
        n_addr         = r_addr;
        n_cnt          = r_cnt;
        n_in_range     = r_in_range;
        n_scrolled     = r_scrolled;
        n_out_valid    = 1'b0;
        n_out_char     = r_out_char;
        n_out_attr     = r_out_attr;
        n_out_col      = r_out_col;
        n_out_row      = r_out_row;
        n_out_scrolled = r_out_scrolled;
        case (r_state)
            tcw_pkg::S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
            end
            tcw_pkg::S_IDLE: begin
                n_cmd      = i_cmd;
                n_scrolled = 1'b0;
                n_in_range = (32'(i_cmd.cell_index) < CELLS);
                if (i_cmd.kind == tcw_pkg::CMD_READ) begin
                    n_lin = AW'(i_cmd.cell_index);
                end else begin
                    n_lin = AW'(r_row * COLUMNS) + AW'(r_col);
                end
            end
            tcw_pkg::S_ADDR: begin
                // logical cell to physical: rows rotate with each scroll
                n_addr = (addr_sum >= CELLS_X) ? AW'(addr_sum - CELLS_X) : AW'(addr_sum);
            end
            tcw_pkg::S_ACCESS: begin
                if (r_cmd.kind != tcw_pkg::CMD_READ) begin
                    if (advance_row) begin
                        n_col = '0;
                        if (row_last) begin
                            n_scrolled = 1'b1;
                            n_cnt      = '0;
                        end else begin
                            n_row = r_row + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                    end
                end
            end
            tcw_pkg::S_SCROLL: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LAST_COL_C) begin
                    n_top_base = (r_top_base == LAST_BASE) ? '0 : r_top_base + COLS_A;
                end
            end
            tcw_pkg::S_DONE: begin
                n_out_valid    = 1'b1;
                n_out_col      = r_col;
                n_out_row      = r_row;
                n_out_scrolled = r_scrolled;
                if ((r_cmd.kind == tcw_pkg::CMD_READ) && r_in_range) begin
                    n_out_char = ram_rdata[tcw_pkg::CHAR_W-1:0];
                    n_out_attr = ram_rdata[DW-1:tcw_pkg::CHAR_W];
                end else begin
                    n_out_char = '0;
                    n_out_attr = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::S_CLEAR;
            r_cnt       <= '0;
            r_col       <= '0;
            r_row       <= '0;
            r_top_base  <= '0;
            r_attr      <= tcw_pkg::RESET_ATTR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_col       <= n_col;
            r_row       <= n_row;
            r_top_base  <= n_top_base;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_attr <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd          <= n_cmd;
        r_lin          <= n_lin;
        r_addr         <= n_addr;
        r_in_range     <= n_in_range;
        r_scrolled     <= n_scrolled;
        r_out_char     <= n_out_char;
        r_out_attr     <= n_out_attr;
        r_out_col      <= n_out_col;
        r_out_row      <= n_out_row;
        r_out_scrolled <= n_out_scrolled;
    end

    assign o_clearing     = (r_state == tcw_pkg::S_CLEAR);
    assign o_result_valid = r_out_valid;
    assign o_cell_char    = r_out_char;
    assign o_cell_attr    = r_out_attr;
    assign o_cursor_col   = tcw_pkg::OCOL_W'(r_out_col);
    assign o_cursor_row   = tcw_pkg::OROW_W'(r_out_row);
    assign o_scrolled     = r_out_scrolled;

    a_cursor_in_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_col) < COLUMNS) && (32'(r_row) < ROWS))
        else $error("cursor outside screen");

    a_top_base_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_top_base <= LAST_BASE))
        else $error("scroll base beyond last row");

    a_no_pop_while_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tcw_pkg::S_CLEAR) |-> !o_pop)
        else $error("command taken during clearing pass");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |=> !r_out_valid)
        else $error("result strobe held two cycles");

endmodule

FILE: hdl/text_console_writer.sv
// Top level of the text console writer.
//
// Text console engine with a ROWS x COLUMNS screen of {attribute, character}
// cells and a cursor. A word is taken at a clock edge where start is high and
// busy is low; each word gives exactly one result, shown for one cycle with
// o_result_valid high, and the receiver cannot stall it. After reset the block
// runs a clearing pass over all ROWS*COLUMNS cells of the screen store, with
// busy high. The back end runs each read, put or newline through its IDLE,
// ADDR, ACCESS and DONE states, and the result strobe is registered out of
// DONE. A put or newline that scrolls also passes through SCROLL, which blanks
// the cells of the new bottom row one at a time, since the store has a single
// write port. Scrolling itself moves no data: a rotating row base maps screen
// rows onto the store. A two-word command queue sits between the accepting
// front end and the executing back end, so up to two more words are taken while
// one executes. The user writes text_attribute through i_cfg_we and i_cfg_wdata
// only while the block is idle; the block itself does not enforce this.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         i_operation,
    input  logic [tcw_pkg::CHAR_W-1:0]   i_char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]  i_cell_index,
    input  logic                         i_cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]   i_cfg_wdata,
    output logic                         o_result_valid,
    output logic [tcw_pkg::CHAR_W-1:0]   o_cell_char,
    output logic [tcw_pkg::ATTR_W-1:0]   o_cell_attr,
    output logic [tcw_pkg::OCOL_W-1:0]   o_cursor_col,
    output logic [tcw_pkg::OROW_W-1:0]   o_cursor_row,
    output logic                         o_scrolled
);

    logic          push;
    logic          pop;
    logic          queue_full;
    logic          clearing;
    logic          cmd_valid;
    tcw_pkg::t_cmd cmd;

    // busy: queue full, or screen still being cleared after reset
    assign busy = queue_full | clearing;
    assign push = start & ~busy;

    tcw_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_operation  (i_operation),
        .i_char_code  (i_char_code),
        .i_cell_index (i_cell_index),
        .i_pop        (pop),
        .o_full       (queue_full),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    tcw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_cmd_valid    (cmd_valid),
        .i_cmd          (cmd),
        .o_pop          (pop),
        .o_clearing     (clearing),
        .o_result_valid (o_result_valid),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_scrolled     (o_scrolled)
    );

endmodule

FILE: bench/text_console_writer_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the text console writer: scoreboard, word driver and checks.
module text_console_writer_test;
    import tcw_pkg::*;

    // Screen geometry of the instance under test
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int INDEX_MAX = (1 << INDEX_W) - 1;

    // Operation codes on i_operation
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Quiet time after the last result: a scrolling word blanks a whole row
    localparam int DRAIN_CYCLES  = 2 * COLUMNS + 20;
    // Margin before a register write once all results are in
    localparam int CFG_SETTLE    = 4;
    // Rough number of words per random phase
    localparam int PHASE_WORDS   = 75;
    localparam int RANDOM_PHASES = 4;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [OCOL_W-1:0] cursor_col;
        logic [OROW_W-1:0] cursor_row;
        logic              scrolled;
    } t_console_result;

    // Screen shadow plus the queue of results still owed by the block
    class console_scoreboard;
        bit [CHAR_W-1:0] screen_char [CELLS];
        bit [ATTR_W-1:0] screen_attr [CELLS];
        int              cursor_x;
        int              cursor_y;
        bit [ATTR_W-1:0] text_attr;
        t_console_result owed_q [$];
        int              mismatches;

        function new();
            for (int i = 0; i < CELLS; i++) begin
                screen_char[i] = BLANK_CODE;
                screen_attr[i] = RESET_ATTR;
            end
            cursor_x   = 0;
            cursor_y   = 0;
            text_attr  = RESET_ATTR;
            mismatches = 0;
        endfunction

        // Apply one accepted word to the shadow and queue the result it owes
        function void note_word(bit op, bit [CHAR_W-1:0] code, bit [INDEX_W-1:0] idx);
            t_console_result r;
            r = '0;
            if (op == OP_READ) begin
                // out-of-range reads return zeros and touch nothing
                if (idx < CELLS) begin
                    r.cell_char = screen_char[idx];
                    r.cell_attr = screen_attr[idx];
                end
            end else begin
                if (code == NEWLINE_CODE) begin
                    // newline writes nothing, just moves the cursor
                    cursor_x = 0;
                    cursor_y++;
                end else begin
                    screen_char[cursor_y * COLUMNS + cursor_x] = code;
                    screen_attr[cursor_y * COLUMNS + cursor_x] = text_attr;
                    cursor_x++;
                    if (cursor_x == COLUMNS) begin
                        cursor_x = 0;
                        cursor_y++;
                    end
                end
                // past the last row: shift up one row, blank the bottom one
                if (cursor_y == ROWS) begin
                    for (int i = 0; i < CELLS - COLUMNS; i++) begin
                        screen_char[i] = screen_char[i + COLUMNS];
                        screen_attr[i] = screen_attr[i + COLUMNS];
                    end
                    for (int i = CELLS - COLUMNS; i < CELLS; i++) begin
                        screen_char[i] = BLANK_CODE;
                        screen_attr[i] = text_attr;
                    end
                    cursor_y   = ROWS - 1;
                    r.scrolled = 1'b1;
                end
            end
            r.cursor_col = OCOL_W'(cursor_x);
            r.cursor_row = OROW_W'(cursor_y);
            owed_q.push_back(r);
        endfunction

        function void compare_field(string field, logic [15:0] want, logic [15:0] seen);
            if (seen !== want) begin
                $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
                mismatches++;
            end
        endfunction

        function void check_result(t_console_result seen);
            t_console_result want;
            if (owed_q.size() == 0) begin
                $error("result strobe with no word outstanding (col %0d row %0d)",
                       seen.cursor_col, seen.cursor_row);
                mismatches++;
                return;
            end
            want = owed_q.pop_front();
            compare_field("cell_char",  16'(want.cell_char),  16'(seen.cell_char));
            compare_field("cell_attr",  16'(want.cell_attr),  16'(seen.cell_attr));
            compare_field("cursor_col", 16'(want.cursor_col), 16'(seen.cursor_col));
            compare_field("cursor_row", 16'(want.cursor_row), 16'(seen.cursor_row));
            compare_field("scrolled",   16'(want.scrolled),   16'(seen.scrolled));
        endfunction
    endclass

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic                i_operation    = OP_PUT;
    logic [CHAR_W-1:0]   i_char_code    = '0;
    logic [INDEX_W-1:0]  i_cell_index   = '0;
    logic                i_cfg_we       = 1'b0;
    logic [ATTR_W-1:0]   i_cfg_wdata    = '0;
    logic                o_result_valid;
    logic [CHAR_W-1:0]   o_cell_char;
    logic [ATTR_W-1:0]   o_cell_attr;
    logic [OCOL_W-1:0]   o_cursor_col;
    logic [OROW_W-1:0]   o_cursor_row;
    logic                o_scrolled;

    console_scoreboard sb = new();

    // Sender pacing: with idling on, send_word may hold start low before each word
    bit idle_on = 1'b1;
    int phase_words;

    text_console_writer #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_char_code    (i_char_code),
        .i_cell_index   (i_cell_index),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_result_valid (o_result_valid),
        .o_cell_char    (o_cell_char),
        .o_cell_attr    (o_cell_attr),
        .o_cursor_col   (o_cursor_col),
        .o_cursor_row   (o_cursor_row),
        .o_scrolled     (o_scrolled)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Results cannot be stalled, so every strobe is taken at the edge that ends it.
    // Values read here are the ones settled before the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            sb.check_result({o_cell_char, o_cell_attr, o_cursor_col, o_cursor_row,
                             o_scrolled});
        end
    end

    // Hand one word to the block. Called at a clock edge; returns at the edge that
    // accepted the word with start still high, so a back-to-back word keeps start
    // up without a low pulse in between.
    task automatic send_word(logic op, logic [CHAR_W-1:0] code, logic [INDEX_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_operation  <= op;
        i_char_code  <= code;
        i_cell_index <= idx;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
        end
        sb.note_word(op, code, idx);
        phase_words++;
    endtask

    // Drop start, let every owed result come back, then write the attribute
    task automatic set_text_attribute(logic [ATTR_W-1:0] value);
        start <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (CFG_SETTLE) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.text_attr = value;
    endtask

    // Any byte but newline
    function automatic logic [CHAR_W-1:0] text_code();
        logic [CHAR_W-1:0] code;
        do code = CHAR_W'($urandom_range(0, 255)); while (code == NEWLINE_CODE);
        return code;
    endfunction

    // Mostly cells around the cursor, where fresh text lands; some anywhere,
    // a few past the end of the screen
    function automatic logic [INDEX_W-1:0] read_index();
        int pick;
        int row;
        pick = $urandom_range(0, 9);
        row  = sb.cursor_y;
        if (row > 0 && $urandom_range(0, 1) == 1) row--;
        if (pick < 6) return INDEX_W'(row * COLUMNS + $urandom_range(0, COLUMNS - 1));
        if (pick < 9) return INDEX_W'($urandom_range(0, CELLS - 1));
        return INDEX_W'($urandom_range(CELLS, INDEX_MAX));
    endfunction

    // One random burst: a line of text, a run of reads, a run of newlines, or noise
    task automatic random_burst();
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // some lines run just short of, up to, or past the row end
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(COLUMNS - 5, COLUMNS + 5)
                                              : $urandom_range(0, 12);
            repeat (len) send_word(OP_PUT, text_code(), INDEX_W'($urandom_range(0, INDEX_MAX)));
            if ($urandom_range(0, 9) < 8)
                send_word(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, INDEX_MAX)));
        end else if (pick < 60) begin
            repeat ($urandom_range(1, 6))
                send_word(OP_READ, CHAR_W'($urandom_range(0, 255)), read_index());
        end else if (pick < 85) begin
            // newline runs drive the cursor to the bottom and keep scrolling
            repeat ($urandom_range(1, 10))
                send_word(OP_PUT, NEWLINE_CODE, INDEX_W'($urandom_range(0, INDEX_MAX)));
        end else begin
            repeat ($urandom_range(1, 4))
                send_word(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)),
                          INDEX_W'($urandom_range(0, INDEX_MAX)));
        end
        // about one burst in four runs with no sender gaps
        idle_on = ($urandom_range(0, 3) != 0);
    endtask

    initial begin
        logic [ATTR_W-1:0] attr;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the block clears its screen store after reset with busy high
        repeat (2) @(posedge i_clk);
        while (busy) @(posedge i_clk);

        // Directed words, reset attribute still in force.
        // Reset contents, last cell, and reads past the screen end
        send_word(OP_READ, 8'h00, INDEX_W'(0));
        send_word(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
        send_word(OP_READ, 8'h00, INDEX_W'(CELLS));
        send_word(OP_READ, 8'hFF, INDEX_W'(INDEX_MAX));
        // Character extremes, then a newline that writes nothing
        send_word(OP_PUT, 8'h41, INDEX_W'(0));
        send_word(OP_PUT, 8'h00, INDEX_W'(INDEX_MAX));
        send_word(OP_PUT, 8'hFF, INDEX_W'(0));
        send_word(OP_PUT, NEWLINE_CODE, INDEX_W'(INDEX_MAX));
        send_word(OP_READ, 8'h00, INDEX_W'(0));
        send_word(OP_READ, 8'h00, INDEX_W'(1));
        send_word(OP_READ, 8'h00, INDEX_W'(2));
        send_word(OP_READ, 8'h00, INDEX_W'(3));
        send_word(OP_READ, 8'h00, INDEX_W'(COLUMNS));
        // Alternating bit patterns on the second row
        send_word(OP_PUT, 8'h55, INDEX_W'(0));
        send_word(OP_PUT, 8'hAA, INDEX_W'(0));
        send_word(OP_READ, 8'h00, INDEX_W'(COLUMNS));
        send_word(OP_READ, 8'h00, INDEX_W'(COLUMNS + 1));

        // Random phases: attribute extremes first, then random values
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0:       attr = '0;
                1:       attr = '1;
                default: attr = ATTR_W'($urandom_range(0, 255));
            endcase
            set_text_attribute(attr);
            phase_words = 0;
            while (phase_words < PHASE_WORDS) random_burst();
        end

        start <= 1'b0;
        while (sb.owed_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: well beyond the slowest legal run (clear pass, every word scrolling,
    // every sender gap at its longest)
    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
